FILE: hw/rtl/dbc_pkg.sv
// Shared constants and register indexes for the Dalitz boundary check.
package dbc_pkg;

  localparam int MASS_WIDTH_DEF = 20;
  localparam int MSQ_WIDTH_DEF  = 24;

  // Fraction bits of the fixed-point mass format
  localparam int FRAC_BITS = 16;

  // Square root digits resolved per pipeline stage
  localparam int SQRT_STEPS_PER_STAGE = 2;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PARENT_MASS = 2'd0,
    CFG_DAU1_MASS   = 2'd1,
    CFG_DAU2_MASS   = 2'd2,
    CFG_DAU3_MASS   = 2'd3
  } cfg_idx_t;

endpackage

FILE: hw/rtl/dbc_isqrt.sv
// Pipelined floor square root, a fixed number of digits per stage.
module dbc_isqrt #(
  parameter int IN_W            = 56,
  parameter int STEPS_PER_STAGE = 2
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [IN_W-1:0]       rad,
  output logic [(IN_W+1)/2-1:0] root
);
  import dbc_pkg::*;

  localparam int RW   = (IN_W + 1) / 2;
  localparam int NST  = (RW + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int TW   = NST * STEPS_PER_STAGE;
  localparam int REMW = TW + 2;

  logic [REMW-1:0] rem_r  [1:NST];
  logic [TW-1:0]   root_r [1:NST];
  logic [2*TW-1:0] rest_r [1:NST];

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic [REMW-1:0] rem_in;
    logic [TW-1:0]   root_in;
    logic [2*TW-1:0] rest_in;
    logic [REMW-1:0] rem_o;
    logic [TW-1:0]   root_o;
    logic [2*TW-1:0] rest_o;

    if (k == 0) begin : g_src_in
      assign rem_in  = '0;
      assign root_in = '0;
      assign rest_in = (2*TW)'(rad);
    end else begin : g_src_reg
      assign rem_in  = rem_r[k];
      assign root_in = root_r[k];
      assign rest_in = rest_r[k];
    end

    // Resolve one root digit per step: bring down two bits, try to subtract
    always_comb begin
      logic [REMW-1:0] trial;
      rem_o  = rem_in;
      root_o = root_in;
      rest_o = rest_in;
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        rem_o  = {rem_o[REMW-3:0], rest_o[2*TW-1 -: 2]};
        rest_o = {rest_o[2*TW-3:0], 2'b00};
        trial  = {root_o, 2'b01};
        if (rem_o >= trial) begin
          rem_o  = rem_o - trial;
          root_o = {root_o[TW-2:0], 1'b1};
        end else begin
          root_o = {root_o[TW-2:0], 1'b0};
        end
      end
    end

    // Advance the partial root
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= rem_o;
        root_r[k+1] <= root_o;
        rest_r[k+1] <= rest_o;
      end
    end
  end

  assign root = root_r[NST][RW-1:0];

endmodule

FILE: hw/rtl/dalitz_boundary_check.sv
// Dalitz region test for a three-body decay: box test and exact boundary.
//
// Usage: write the parent mass and three daughter masses through the cfg
// port (index 0 parent, 1..3 daughters; 2^-16 GeV units) while idle. Each
// input beat carries (m12^2, m23^2) in 2^-16 GeV^2 units; each yields one
// output beat with in_box (rectangular limits) and inside_res (exact
// kinematic boundary, zero when m12^2 is zero or outside the box).
//
// From input beat to output beat, four stages capture the beat, form the
// box test and energy terms, the products and the radicands; the square
// root pipeline resolves two root bits per stage, and two stages form the
// root product and the final compares.
// Throughput: one beat per cycle while the output beat is not stalled.
// A stalled output beat freezes the whole pipeline; in_stall follows
// out_stall while the output register holds a beat. Nothing is dropped.
// Reset clears all valid bits and the mass registers to zero.
module dalitz_boundary_check #(
  parameter int MASS_WIDTH = dbc_pkg::MASS_WIDTH_DEF,
  parameter int MSQ_WIDTH  = dbc_pkg::MSQ_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dbc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [MASS_WIDTH-1:0]          cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [MSQ_WIDTH-1:0]    in_msq_ab,
  input  logic signed [MSQ_WIDTH-1:0]    in_msq_bc,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_in_box,
  output logic                           out_inside_res
);
  import dbc_pkg::*;

  localparam int MW  = MASS_WIDTH;
  localparam int SW  = MSQ_WIDTH;
  localparam int QW  = 2*MW + 2 - FRAC_BITS;
  localparam int XW  = ((SW > QW) ? SW : QW) + 1;
  localparam int AW  = XW + 1;
  localparam int PW  = 2*AW + 2;
  localparam int RW  = PW / 2;
  localparam int NST = (RW + SQRT_STEPS_PER_STAGE - 1) / SQRT_STEPS_PER_STAGE;
  localparam int CW  = 2*AW + 4;
  localparam int DEPTH = 6 + NST;

  // Mass registers
  logic [MW-1:0] mp_r, m1_r, m2_r, m3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mp_r <= '0;
      m1_r <= '0;
      m2_r <= '0;
      m3_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_PARENT_MASS: mp_r <= cfg_wdata;
        CFG_DAU1_MASS:   m1_r <= cfg_wdata;
        CFG_DAU2_MASS:   m2_r <= cfg_wdata;
        CFG_DAU3_MASS:   m3_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Squared masses and box limits, derived from the mass registers
  logic [MW:0]     sum12, sum23;
  logic [MW-1:0]   dif3, dif1;
  logic [2*MW+1:0] psum12, psum23;
  logic [2*MW-1:0] pdif3, pdif1, pm, p1, p2, p3;
  logic [QW-1:0]   lo12_r, hi12_r, lo23_r, hi23_r, qm_r, q1_r, q2_r, q3_r;

  assign sum12  = {1'b0, m1_r} + {1'b0, m2_r};
  assign sum23  = {1'b0, m2_r} + {1'b0, m3_r};
  assign dif3   = (mp_r >= m3_r) ? mp_r - m3_r : m3_r - mp_r;
  assign dif1   = (mp_r >= m1_r) ? mp_r - m1_r : m1_r - mp_r;
  assign psum12 = sum12 * sum12;
  assign psum23 = sum23 * sum23;
  assign pdif3  = dif3 * dif3;
  assign pdif1  = dif1 * dif1;
  assign pm     = mp_r * mp_r;
  assign p1     = m1_r * m1_r;
  assign p2     = m2_r * m2_r;
  assign p3     = m3_r * m3_r;

  always_ff @(posedge clk) begin
    lo12_r <= psum12[2*MW+1:FRAC_BITS];
    lo23_r <= psum23[2*MW+1:FRAC_BITS];
    hi12_r <= QW'(pdif3[2*MW-1:FRAC_BITS]);
    hi23_r <= QW'(pdif1[2*MW-1:FRAC_BITS]);
    qm_r   <= QW'(pm[2*MW-1:FRAC_BITS]);
    q1_r   <= QW'(p1[2*MW-1:FRAC_BITS]);
    q2_r   <= QW'(p2[2*MW-1:FRAC_BITS]);
    q3_r   <= QW'(p3[2*MW-1:FRAC_BITS]);
  end

  // Pipeline enable: freeze everything while the output beat is stalled
  logic en;
  logic vld_r [0:DEPTH-1];

  assign en       = !(vld_r[DEPTH-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < DEPTH; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // Stage 1: capture the input beat
  logic signed [SW-1:0] s1_r, t1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= in_msq_ab;
      t1_r <= in_msq_bc;
    end
  end

  // Stage 2: box test and energy terms
  logic signed [XW-1:0] sx, tx, lo12x, hi12x, lo23x, hi23x, qmx, q1x, q2x, q3x;
  logic signed [AW-1:0] a2_r, b2_r, d2_r, s2_r, q2s_r, q3s_r;
  logic                 box2_r, nz2_r;

  assign sx    = XW'(s1_r);
  assign tx    = XW'(t1_r);
  assign lo12x = $signed(XW'(lo12_r));
  assign hi12x = $signed(XW'(hi12_r));
  assign lo23x = $signed(XW'(lo23_r));
  assign hi23x = $signed(XW'(hi23_r));
  assign qmx   = $signed(XW'(qm_r));
  assign q1x   = $signed(XW'(q1_r));
  assign q2x   = $signed(XW'(q2_r));
  assign q3x   = $signed(XW'(q3_r));

  always_ff @(posedge clk) begin
    if (en) begin
      box2_r <= (sx >= lo12x) && (sx < hi12x) && (tx >= lo23x) && (tx < hi23x);
      nz2_r  <= (s1_r != '0);
      a2_r   <= AW'(sx) - AW'(q1x) + AW'(q2x);
      b2_r   <= AW'(qmx) - AW'(sx) - AW'(q3x);
      d2_r   <= AW'(tx) - AW'(q2x) - AW'(q3x);
      s2_r   <= AW'(sx);
      q2s_r  <= AW'(q2x);
      q3s_r  <= AW'(q3x);
    end
  end

  // Stage 3: products
  logic signed [2*AW-1:0] aa3_r, bb3_r, sq2_3_r, sq3_3_r, ab3_r, sd3_r;
  logic                   box3_r, go3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      aa3_r   <= a2_r * a2_r;
      bb3_r   <= b2_r * b2_r;
      sq2_3_r <= s2_r * q2s_r;
      sq3_3_r <= s2_r * q3s_r;
      ab3_r   <= a2_r * b2_r;
      sd3_r   <= s2_r * d2_r;
      box3_r  <= box2_r;
      go3_r   <= box2_r && nz2_r;
    end
  end

  // Stage 4: radicands, clamped at zero
  logic signed [PW-1:0]   pr, qr;
  logic [PW-2:0]          p4_r, q4_r;
  logic signed [2*AW-1:0] ab4_r;
  logic signed [CW-1:0]   lhs4_r;
  logic                   box4_r, go4_r;

  assign pr = PW'(aa3_r) - (PW'(sq2_3_r) <<< 2);
  assign qr = PW'(bb3_r) - (PW'(sq3_3_r) <<< 2);

  always_ff @(posedge clk) begin
    if (en) begin
      p4_r   <= pr[PW-1] ? '0 : pr[PW-2:0];
      q4_r   <= qr[PW-1] ? '0 : qr[PW-2:0];
      ab4_r  <= ab3_r;
      lhs4_r <= CW'(sd3_r) <<< 1;
      box4_r <= box3_r;
      go4_r  <= go3_r;
    end
  end

  // Square roots of both radicands
  logic [RW-1:0] rp, rq;

  dbc_isqrt #(.IN_W(PW-1), .STEPS_PER_STAGE(SQRT_STEPS_PER_STAGE)) u_sqrt_p (
    .clk  (clk),
    .en   (en),
    .rad  (p4_r),
    .root (rp)
  );

  dbc_isqrt #(.IN_W(PW-1), .STEPS_PER_STAGE(SQRT_STEPS_PER_STAGE)) u_sqrt_q (
    .clk  (clk),
    .en   (en),
    .rad  (q4_r),
    .root (rq)
  );

  // Carry the side data alongside the root pipeline
  logic signed [2*AW-1:0] ab_d_r  [0:NST-1];
  logic signed [CW-1:0]   lhs_d_r [0:NST-1];
  logic                   box_d_r [0:NST-1];
  logic                   go_d_r  [0:NST-1];

  always_ff @(posedge clk) begin
    if (en) begin
      ab_d_r[0]  <= ab4_r;
      lhs_d_r[0] <= lhs4_r;
      box_d_r[0] <= box4_r;
      go_d_r[0]  <= go4_r;
      for (int i = 1; i < NST; i++) begin
        ab_d_r[i]  <= ab_d_r[i-1];
        lhs_d_r[i] <= lhs_d_r[i-1];
        box_d_r[i] <= box_d_r[i-1];
        go_d_r[i]  <= go_d_r[i-1];
      end
    end
  end

  // Root product
  logic [2*RW-1:0]        rpq;
  logic signed [2*RW:0]   r5_r;
  logic signed [2*AW-1:0] ab5_r;
  logic signed [CW-1:0]   lhs5_r;
  logic                   box5_r, go5_r;

  assign rpq = rp * rq;

  always_ff @(posedge clk) begin
    if (en) begin
      r5_r   <= $signed({1'b0, rpq});
      ab5_r  <= ab_d_r[NST-1];
      lhs5_r <= lhs_d_r[NST-1];
      box5_r <= box_d_r[NST-1];
      go5_r  <= go_d_r[NST-1];
    end
  end

  // Final compares against both boundary branches
  logic signed [CW-1:0] abc, rc;
  logic                 box_o_r, inside_o_r;

  assign abc = CW'(ab5_r);
  assign rc  = CW'(r5_r);

  always_ff @(posedge clk) begin
    if (en) begin
      box_o_r    <= box5_r;
      inside_o_r <= go5_r && (lhs5_r >= abc - rc) && (lhs5_r < abc + rc);
    end
  end

  assign out_valid      = vld_r[DEPTH-1];
  assign out_in_box     = box_o_r;
  assign out_inside_res = inside_o_r;

endmodule

FILE: hw/rtl/dbc_checker.sv
// Port-level checks for the Dalitz boundary check, bound to the top level.
module dbc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_in_box,
  input logic out_inside_res
);

  // A stalled output beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped under stall");

  // Exact boundary only inside the box
  a_inside_box: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_inside_res |-> out_in_box)
    else $error("inside_res set outside the box");

  // Input stalls only behind a stalled output beat
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output beat after reset");

endmodule

bind dalitz_boundary_check dbc_checker u_dbc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_in_box     (out_in_box),
  .out_inside_res (out_inside_res)
);

FILE: sim/testbench.sv
// Self-checking testbench for the Dalitz boundary check block.
`timescale 1ns / 1ps

module testbench;
  import dbc_pkg::*;

  localparam int MW = MASS_WIDTH_DEF;
  localparam int SW = MSQ_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic in_box;
    logic inside_hit;
  } dalitz_verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [MW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SW-1:0] in_msq_ab = '0;
  logic signed [SW-1:0] in_msq_bc = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_in_box;
  logic out_inside_res;

  // Predictor copy of the mass registers
  logic [MW-1:0] mass_reg [4];
  dalitz_verdict_t verdict_q [$];
  int mismatches = 0;
  int cycles = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  dalitz_boundary_check dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_msq_ab(in_msq_ab), .in_msq_bc(in_msq_bc),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_in_box(out_in_box), .out_inside_res(out_inside_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Squared mass, truncated to 2^-16 GeV^2
  function automatic logic [63:0] square_mass(input logic [63:0] x);
    return (x * x) >> 16;
  endfunction

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] root, bit_w;
    root = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= root + bit_w) begin
        v = v - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else begin
        root = root >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return root;
  endfunction

  function automatic logic [63:0] mass_gap(input logic [63:0] a, input logic [63:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Box limits: 0 lower m12^2, 1 upper m12^2, 2 lower m23^2, 3 upper m23^2
  function automatic logic [63:0] box_edge(input int which);
    logic [63:0] pm, d1, d2, d3;
    pm = mass_reg[0]; d1 = mass_reg[1]; d2 = mass_reg[2]; d3 = mass_reg[3];
    case (which)
      0: return square_mass(d1 + d2);
      1: return square_mass(mass_gap(pm, d3));
      2: return square_mass(d2 + d3);
      default: return square_mass(mass_gap(pm, d1));
    endcase
  endfunction

  function automatic dalitz_verdict_t judge_point(input logic [SW-1:0] ab,
                                                  input logic [SW-1:0] bc);
    dalitz_verdict_t v;
    logic [63:0] s, t, qm, q2, q3, a, b, p, q, r, ab_prod, lhs;
    s = {{(64-SW){ab[SW-1]}}, ab};
    t = {{(64-SW){bc[SW-1]}}, bc};
    v.in_box = ($signed(s) >= $signed(box_edge(0))) && ($signed(s) < $signed(box_edge(1)))
            && ($signed(t) >= $signed(box_edge(2))) && ($signed(t) < $signed(box_edge(3)));
    v.inside_hit = 1'b0;
    if (v.in_box && s != 0) begin
      qm = square_mass(mass_reg[0]);
      q2 = square_mass(mass_reg[2]);
      q3 = square_mass(mass_reg[3]);
      a = s - square_mass(mass_reg[1]) + q2;
      b = qm - s - q3;
      p = a * a - 4 * s * q2;
      q = b * b - 4 * s * q3;
      // clamp a negative radicand
      if (p[63]) p = 0;
      if (q[63]) q = 0;
      r = floor_root(p) * floor_root(q);
      ab_prod = a * b;
      lhs = 2 * s * (t - q2 - q3);
      v.inside_hit = ($signed(lhs) >= $signed(ab_prod - r))
                  && ($signed(lhs) < $signed(ab_prod + r));
    end
    return v;
  endfunction

  // Check each result beat and draw the next receiver stall
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result beat: in_box=%0b inside=%0b",
                                      out_in_box, out_inside_res);
      end else begin
        dalitz_verdict_t want;
        want = verdict_q.pop_front();
        if (want.in_box !== out_in_box || want.inside_hit !== out_inside_res) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: in_box exp %0b got %0b, inside_res exp %0b got %0b",
                     want.in_box, out_in_box, want.inside_hit, out_inside_res);
        end
      end
      stall_left = quiet ? 0 : $urandom_range(0, 13);
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end
    out_stall <= (stall_left != 0);
  end

  task automatic write_mass(input cfg_idx_t idx, input logic [MW-1:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    mass_reg[idx] = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_masses(input logic [MW-1:0] pm, input logic [MW-1:0] d1,
                             input logic [MW-1:0] d2, input logic [MW-1:0] d3);
    write_mass(CFG_PARENT_MASS, pm);
    write_mass(CFG_DAU1_MASS, d1);
    write_mass(CFG_DAU2_MASS, d2);
    write_mass(CFG_DAU3_MASS, d3);
  endtask

  // Send one point, holding the beat until it is taken
  task automatic send_point(input logic [SW-1:0] ab, input logic [SW-1:0] bc);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_msq_ab <= ab;
    in_msq_bc <= bc;
    do @(posedge clk); while (in_stall);
    verdict_q.insert(verdict_q.size(), judge_point(ab, bc));
  endtask

  // Drop valid and wait for every outstanding result, then let the pipe settle
  task automatic drain;
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Value near a range [lo, hi), a few LSBs either side
  function automatic logic [SW-1:0] near_range(input logic [63:0] lo, input logic [63:0] hi);
    longint span;
    span = longint'(hi) - longint'(lo);
    if (span <= 0) span = 1;
    if (span > 64'd100000000) span = 100000000;
    return SW'(longint'(lo) - 3 + longint'($urandom_range(0, int'(span) + 5)));
  endfunction

  task automatic test_directed;
    logic [63:0] l12, h12, l23, h23;
    load_masses(MW'(196608), MW'(9175), MW'(32113), MW'(9175));
    l12 = box_edge(0); h12 = box_edge(1); l23 = box_edge(2); h23 = box_edge(3);
    send_point(SW'(0), SW'((l23 + h23) / 2));
    send_point({1'b1, {(SW-1){1'b0}}}, {1'b1, {(SW-1){1'b0}}});
    send_point({1'b0, {(SW-1){1'b1}}}, {1'b0, {(SW-1){1'b1}}});
    send_point(SW'(-1), SW'(-1));
    send_point(SW'(l12), SW'((l23 + h23) / 2));
    send_point(SW'(l12 - 1), SW'((l23 + h23) / 2));
    send_point(SW'(h12 - 1), SW'(l23));
    send_point(SW'(h12), SW'(l23));
    send_point(SW'((l12 + h12) / 2), SW'(l23));
    send_point(SW'((l12 + h12) / 2), SW'(h23 - 1));
    send_point(SW'((l12 + h12) / 2), SW'(h23));
    send_point(SW'((l12 + h12) / 2), SW'((l23 + h23) / 2));
    send_point(SW'(l12 + 1), SW'(l23 + 1));
    drain();
    // parent lighter than a daughter
    load_masses(MW'(20000), MW'(90000), MW'(5000), MW'(60000));
    send_point(SW'(box_edge(0)), SW'(box_edge(2)));
    send_point(SW'((box_edge(0) + box_edge(1)) / 2), SW'((box_edge(2) + box_edge(3)) / 2));
    send_point(SW'(box_edge(1) - 1), SW'(box_edge(3) - 1));
    drain();
    // widest masses
    load_masses({MW{1'b1}}, {MW{1'b1}}, {MW{1'b1}}, {MW{1'b1}});
    send_point({1'b0, {(SW-1){1'b1}}}, SW'(12345));
    send_point(SW'(0), SW'(0));
    drain();
  endtask

  task automatic test_random_points(input int count);
    logic [SW-1:0] ab, bc;
    for (int i = 0; i < count; i++) begin
      // every 50 points, pick at random a stretch with or without idling
      if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 2) begin
        ab = SW'($urandom);
        bc = SW'($urandom);
      end else begin
        ab = near_range(box_edge(0), box_edge(1));
        bc = near_range(box_edge(2), box_edge(3));
      end
      send_point(ab, bc);
      // hold off once mid-phase until the pipe is empty
      if (i == count / 2) drain();
    end
    quiet = 1'b0;
    drain();
  endtask

  task automatic test_mass_settings;
    load_masses(MW'(196608), MW'(9175), MW'(32113), MW'(9175));
    test_random_points(300);
    load_masses(MW'(350000), MW'(34600), MW'(9175), MW'(64000));
    test_random_points(300);
    load_masses(MW'($urandom), MW'($urandom_range(0, 200000)),
                MW'($urandom_range(0, 200000)), MW'($urandom_range(0, 200000)));
    test_random_points(250);
    load_masses(MW'(0), MW'(0), MW'(0), MW'(0));
    test_random_points(50);
    load_masses({MW{1'b1}}, MW'(1), MW'(0), {MW{1'b1}});
    test_random_points(50);
    load_masses(MW'(65536), MW'(20000), MW'(20000), MW'(20000));
    test_random_points(250);
  endtask

  initial begin
    for (int i = 0; i < 4; i++) mass_reg[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_mass_settings();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/dbc_pkg.sv
hw/rtl/dbc_isqrt.sv
hw/rtl/dalitz_boundary_check.sv
hw/rtl/dbc_checker.sv
sim/testbench.sv
